@@ hw/rtl/swin_pkg.sv @@
package swin_pkg;

	localparam int SEQ_W       = 16;
	localparam int WIN_CFG_W   = 5;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef logic [SEQ_W-1:0]     seq_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WIN_CFG_W-1:0] win_cfg_t;
	typedef logic [1:0]           mode_t;
	typedef logic [2:0]           kind_t;
	typedef logic                 reg_index_t;

	localparam mode_t MODE_SEND   = 2'd0;
	localparam mode_t MODE_ACK    = 2'd1;
	localparam mode_t MODE_TICK   = 2'd2;
	localparam mode_t MODE_UNUSED = 2'd3;

	localparam kind_t KIND_NEW     = 3'd0;
	localparam kind_t KIND_RESEND  = 3'd1;
	localparam kind_t KIND_ACK_OK  = 3'd2;
	localparam kind_t KIND_ACK_BAD = 3'd3;
	localparam kind_t KIND_NONE    = 3'd4;

	localparam reg_index_t REG_WIN_LEN   = 1'b0;
	localparam reg_index_t REG_PKT_COUNT = 1'b1;

	localparam win_cfg_t WIN_LEN_RESET   = 5'd4;
	localparam seq_t     PKT_COUNT_RESET = 16'd16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEND_ROOM,
		S_SEND_CNT,
		S_SEND_EMIT,
		S_ACK_CHK,
		S_ACK_ADV,
		S_TO_CNT,
		S_TO_EMIT,
		S_EMIT_ONE
	} state_t;

endpackage

@@ hw/rtl/swin_cmd_if.sv @@
interface swin_cmd_if;
	import swin_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	seq_t  ack_seq;

	modport source (output valid, output mode, output ack_seq, input ready);
	modport sink (input valid, input mode, input ack_seq, output ready);

endinterface

@@ hw/rtl/swin_res_if.sv @@
interface swin_res_if;
	import swin_pkg::*;

	logic  valid;
	logic  ready;
	seq_t  seq;
	kind_t kind;
	seq_t  window_base;
	seq_t  next_number;
	logic  done_res;
	logic  last;

	modport source (
		output valid, output seq, output kind, output window_base,
		output next_number, output done_res, output last, input ready
	);
	modport sink (
		input valid, input seq, input kind, input window_base,
		input next_number, input done_res, input last, output ready
	);

endinterface

@@ hw/rtl/sliding_window_sender_top.sv @@
// channel  | dir | handshake     | payload
// cmd      | in  | valid/ready   | mode, ack_seq
// res      | out | valid/ready   | seq, kind, window_base, next_number, done_res, last
// cfg      | in  | wr_en only    | wr_index, wr_data (0 window length, 1 packet count)
//
// one command at a time; cmd.ready is high only while the sequencer is idle
// send: S_SEND_ROOM and S_SEND_CNT size the burst, then one beat per cycle unless res stalls (n new numbers)
// ack: S_ACK_CHK checks and marks, S_ACK_ADV frees each acked slot at the base, then one beat
// timeout: S_TO_CNT walks the outstanding slots to count, then S_TO_EMIT walks the window again, one slot per
//   cycle unless res stalls, while resends go out
// the slot walks reuse one pointer, ptr_q; res stalls hold the walk
// reset clears base, next and the acked map at once; no clearing pass
module sliding_window_sender_top #(
	parameter int WINDOW_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	swin_cmd_if.sink             cmd,
	swin_res_if.source           res,
	input  logic                 wr_en,
	input  swin_pkg::reg_index_t wr_index,
	input  swin_pkg::seq_t       wr_data
);
	import swin_pkg::*;

	localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	typedef logic [SW-1:0] slot_t;

	function automatic slot_t slot_inc(input slot_t s);
		slot_t r;
		r = (s == SW'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
		return r;
	endfunction

	state_t state_q, state_d;

	win_cfg_t win_len_q;
	seq_t     pkt_count_q;

	seq_t  base_q, next_q, ptr_q, ack_q, one_seq_q;
	slot_t base_slot_q, pslot_q;
	logic [WINDOW_MAX-1:0] acked_q;
	cnt_t  cnt_q, emit_q, room_win_q, room_tot_q;
	kind_t one_kind_q;

	logic  res_valid_q, res_done_q, res_last_q;
	seq_t  res_seq_q, res_base_q, res_next_q;
	kind_t res_kind_q;

	logic  out_free, out_load, out_last_d;
	seq_t  out_seq_d;
	kind_t out_kind_d;

	// window room and packet room, both capped at one burst
	logic [SEQ_W:0] win_ext, lim, room_win_x, room_tot_x;
	cnt_t send_cnt;
	always_comb begin
		win_ext = ({{(SEQ_W + 1 - WIN_CFG_W){1'b0}}, win_len_q} > (SEQ_W + 1)'(WINDOW_MAX))
			? (SEQ_W + 1)'(WINDOW_MAX) : {{(SEQ_W + 1 - WIN_CFG_W){1'b0}}, win_len_q};
		lim = {1'b0, base_q} + win_ext;
		room_win_x = (lim > {1'b0, next_q}) ? lim - {1'b0, next_q} : '0;
		room_tot_x = (pkt_count_q > next_q)
			? {1'b0, pkt_count_q} - {1'b0, next_q} : '0;
		send_cnt = (room_win_q < room_tot_q) ? room_win_q : room_tot_q;
	end

	// slot of the acked number, relative to the base slot
	seq_t             ack_off;
	logic [SW:0]      ack_sum;
	slot_t            ack_slot;
	logic             ack_in_range;
	always_comb begin
		ack_off      = ack_q - base_q;
		ack_sum      = {1'b0, base_slot_q} + {1'b0, ack_off[SW-1:0]};
		ack_slot     = (ack_sum >= (SW + 1)'(WINDOW_MAX))
			? SW'(ack_sum - (SW + 1)'(WINDOW_MAX)) : ack_sum[SW-1:0];
		ack_in_range = (ack_q >= base_q) && (ack_q < next_q);
	end

	logic ptr_live, pslot_acked, base_acked;
	assign ptr_live    = ptr_q < next_q;
	assign pslot_acked = acked_q[pslot_q];
	assign base_acked  = acked_q[base_slot_q];

	assign out_free = !res_valid_q || res.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd.mode)
						MODE_SEND: state_d = S_SEND_ROOM;
						MODE_ACK:  state_d = S_ACK_CHK;
						MODE_TICK: state_d = S_TO_CNT;
						default:   state_d = S_EMIT_ONE;
					endcase
				end
			end
			S_SEND_ROOM: state_d = S_SEND_CNT;
			S_SEND_CNT:  state_d = (send_cnt == '0) ? S_EMIT_ONE : S_SEND_EMIT;
			S_SEND_EMIT: begin
				if (out_free && (emit_q + 1'b1 == cnt_q)) state_d = S_IDLE;
			end
			S_ACK_CHK: state_d = ack_in_range ? S_ACK_ADV : S_EMIT_ONE;
			S_ACK_ADV: begin
				if (!(base_q != next_q && base_acked)) state_d = S_EMIT_ONE;
			end
			S_TO_CNT: begin
				if (!ptr_live) state_d = (cnt_q == '0) ? S_EMIT_ONE : S_TO_EMIT;
			end
			S_TO_EMIT: begin
				if (!pslot_acked && out_free && (emit_q + 1'b1 == cnt_q)) state_d = S_IDLE;
			end
			S_EMIT_ONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready  = 1'b0;
		out_load   = 1'b0;
		out_seq_d  = ptr_q;
		out_kind_d = KIND_NONE;
		out_last_d = 1'b0;
		unique case (state_q)
			S_IDLE: cmd.ready = 1'b1;
			S_SEND_EMIT: begin
				out_load   = out_free;
				out_kind_d = KIND_NEW;
				out_last_d = (emit_q + 1'b1 == cnt_q);
			end
			S_TO_EMIT: begin
				out_load   = out_free && !pslot_acked;
				out_kind_d = KIND_RESEND;
				out_last_d = (emit_q + 1'b1 == cnt_q);
			end
			S_EMIT_ONE: begin
				out_load   = out_free;
				out_seq_d  = one_seq_q;
				out_kind_d = one_kind_q;
				out_last_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WIN_LEN_RESET;
			pkt_count_q <= PKT_COUNT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIN_LEN:   win_len_q   <= wr_data[WIN_CFG_W-1:0];
				REG_PKT_COUNT: pkt_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	// window state and acked map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			base_slot_q <= '0;
			acked_q     <= '0;
		end else begin
			if (state_q == S_SEND_CNT) next_q <= next_q + SEQ_W'(send_cnt);
			if (state_q == S_ACK_CHK && ack_in_range) acked_q[ack_slot] <= 1'b1;
			if (state_q == S_ACK_ADV && base_q != next_q && base_acked) begin
				acked_q[base_slot_q] <= 1'b0;
				base_q               <= base_q + 1'b1;
				base_slot_q          <= slot_inc(base_slot_q);
			end
		end
	end

	// walk pointer and counters
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ack_q      <= cmd.ack_seq;
				ptr_q      <= base_q;
				pslot_q    <= base_slot_q;
				cnt_q      <= '0;
				emit_q     <= '0;
				one_seq_q  <= '0;
				one_kind_q <= KIND_NONE;
			end
			S_SEND_ROOM: begin
				room_win_q <= (room_win_x > (SEQ_W + 1)'(MAX_RESULTS))
					? CNT_W'(MAX_RESULTS) : room_win_x[CNT_W-1:0];
				room_tot_q <= (room_tot_x > (SEQ_W + 1)'(MAX_RESULTS))
					? CNT_W'(MAX_RESULTS) : room_tot_x[CNT_W-1:0];
			end
			S_SEND_CNT: begin
				cnt_q <= send_cnt;
				ptr_q <= next_q;
			end
			S_SEND_EMIT: begin
				if (out_free) begin
					ptr_q  <= ptr_q + 1'b1;
					emit_q <= emit_q + 1'b1;
				end
			end
			S_ACK_CHK: begin
				one_seq_q  <= ack_q;
				one_kind_q <= ack_in_range ? KIND_ACK_OK : KIND_ACK_BAD;
			end
			S_TO_CNT: begin
				if (ptr_live) begin
					if (!pslot_acked && cnt_q != CNT_W'(MAX_RESULTS)) cnt_q <= cnt_q + 1'b1;
					ptr_q   <= ptr_q + 1'b1;
					pslot_q <= slot_inc(pslot_q);
				end else begin
					ptr_q   <= base_q;
					pslot_q <= base_slot_q;
				end
			end
			S_TO_EMIT: begin
				if (pslot_acked || out_free) begin
					ptr_q   <= ptr_q + 1'b1;
					pslot_q <= slot_inc(pslot_q);
				end
				if (out_load) emit_q <= emit_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_seq_q  <= out_seq_d;
			res_kind_q <= out_kind_d;
			res_base_q <= base_q;
			res_next_q <= next_q;
			res_done_q <= base_q >= pkt_count_q;
			res_last_q <= out_last_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.seq         = res_seq_q;
	assign res.kind        = res_kind_q;
	assign res.window_base = res_base_q;
	assign res.next_number = res_next_q;
	assign res.done_res    = res_done_q;
	assign res.last        = res_last_q;

	a_base_le_next: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= next_q)
		else $error("window base passed next number");

	a_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, next_q} - {1'b0, base_q}) <= (SEQ_W + 1)'(WINDOW_MAX))
		else $error("more numbers outstanding than slots");

	a_base_slot_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && base_q != next_q) |-> !acked_q[base_slot_q])
		else $error("base slot still acked while idle");

	a_resend_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TO_EMIT || state_q == S_SEND_EMIT) |-> (emit_q < cnt_q))
		else $error("more beats emitted than counted");

	a_no_load_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !out_load)
		else $error("result overwritten while stalled");

endmodule

@@ sim/sliding_window_sender_top_tb.sv @@
module sliding_window_sender_top_tb;
	import swin_pkg::*;

	localparam int WIN_SLOTS     = 16;
	localparam int SETTLE_CYCLES = 2 * WIN_SLOTS + 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 80;

	typedef struct {
		seq_t  seq;
		kind_t kind;
		seq_t  window_base;
		seq_t  next_number;
		logic  done_res;
		logic  last;
	} res_beat_t;

	// tracks base, next and the acked map and queues the beats each command should cause
	class window_tracker;
		int unsigned            win_cfg;
		int unsigned            total;
		int unsigned            base;
		int unsigned            nxt;
		bit [WIN_SLOTS-1:0]     acked;
		res_beat_t              pending_beats[$];
		int                     errors;

		function new();
			win_cfg = WIN_LEN_RESET;
			total   = PKT_COUNT_RESET;
			base    = 0;
			nxt     = 0;
			acked   = '0;
			errors  = 0;
		endfunction

		function void set_reg(reg_index_t idx, seq_t data);
			if (idx == REG_WIN_LEN) begin
				win_cfg = data[WIN_CFG_W-1:0];
			end else begin
				total = data;
			end
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		function void note_cmd(mode_t m, seq_t a);
			int unsigned w;
			seq_t        seqs[$];
			kind_t       kinds[$];
			res_beat_t   b;
			w = (win_cfg > WIN_SLOTS) ? WIN_SLOTS : win_cfg;
			case (m)
				MODE_SEND: begin
					while (seqs.size() < MAX_RESULTS && nxt < base + w && nxt < total) begin
						seqs.push_back(seq_t'(nxt));
						kinds.push_back(KIND_NEW);
						nxt++;
					end
				end
				MODE_ACK: begin
					if (a >= base && a < nxt) begin
						acked[a % WIN_SLOTS] = 1'b1;
						// slide the base over the run of acked slots at the base, freeing each one
						while (base < nxt && acked[base % WIN_SLOTS]) begin
							acked[base % WIN_SLOTS] = 1'b0;
							base++;
						end
						kinds.push_back(KIND_ACK_OK);
					end else begin
						kinds.push_back(KIND_ACK_BAD);
					end
					seqs.push_back(a);
				end
				MODE_TICK: begin
					for (int unsigned i = base; i < nxt && seqs.size() < MAX_RESULTS; i++) begin
						if (!acked[i % WIN_SLOTS]) begin
							seqs.push_back(seq_t'(i));
							kinds.push_back(KIND_RESEND);
						end
					end
				end
				default: ;
			endcase
			if (seqs.size() == 0) begin
				seqs.push_back('0);
				kinds.push_back(KIND_NONE);
			end
			foreach (seqs[k]) begin
				b.seq         = seqs[k];
				b.kind        = kinds[k];
				b.window_base = seq_t'(base);
				b.next_number = seq_t'(nxt);
				b.done_res    = (base >= total);
				b.last        = (k == seqs.size() - 1);
				pending_beats.push_back(b);
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task cmp_field(string name, int unsigned got, int unsigned want, res_beat_t w);
			if (got != want) begin
				report_mismatch($sformatf("%s got %0d want %0d (beat seq %0d kind %0d)",
					name, got, want, w.seq, w.kind));
			end
		endtask

		task check_beat(res_beat_t got);
			res_beat_t want;
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat seq %0d kind %0d",
					got.seq, got.kind));
				return;
			end
			want = pending_beats.pop_front();
			cmp_field("seq", got.seq, want.seq, want);
			cmp_field("kind", got.kind, want.kind, want);
			cmp_field("window_base", got.window_base, want.window_base, want);
			cmp_field("next_number", got.next_number, want.next_number, want);
			cmp_field("done_res", got.done_res, want.done_res, want);
			cmp_field("last", got.last, want.last, want);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	reg_index_t wr_index;
	seq_t       wr_data;

	int tx_idle_pct;
	int rx_idle_pct;
	int idle_cycles;

	window_tracker sb;

	swin_cmd_if cmd_ch();
	swin_res_if res_ch();

	sliding_window_sender_top #(
		.WINDOW_MAX(WIN_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		res_beat_t seen;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				sb.note_cmd(cmd_ch.mode, cmd_ch.ack_seq);
			end
			if (res_ch.valid && res_ch.ready) begin
				seen.seq         = res_ch.seq;
				seen.kind        = res_ch.kind;
				seen.window_base = res_ch.window_base;
				seen.next_number = res_ch.next_number;
				seen.done_res    = res_ch.done_res;
				seen.last        = res_ch.last;
				sb.check_beat(seen);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sliding_window_sender_top test failed");
				$finish;
			end
		end
	end

	// entered and left at a falling edge; valid stays high when commands follow back to back
	task automatic push_cmd(mode_t m, seq_t a);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.mode    <= m;
		cmd_ch.ack_seq <= a;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reconfig(seq_t win_data, seq_t total_data);
		drain();
		wr_en    <= 1'b1;
		wr_index <= REG_WIN_LEN;
		wr_data  <= win_data;
		sb.set_reg(REG_WIN_LEN, win_data);
		@(negedge clk);
		wr_index <= REG_PKT_COUNT;
		wr_data  <= total_data;
		sb.set_reg(REG_PKT_COUNT, total_data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_item();
		int unsigned r;
		mode_t       m;
		seq_t        a;
		r = $urandom_range(99);
		m = MODE_SEND;
		a = seq_t'($urandom);
		if (r < 40) begin
			m = MODE_SEND;
		end else if (r < 75) begin
			// ack somewhere in the outstanding range
			if (sb.nxt > sb.base) begin
				m = MODE_ACK;
				a = seq_t'($urandom_range(sb.nxt - 1, sb.base));
			end
		end else if (r < 85) begin
			m = MODE_TICK;
		end else if (r < 90) begin
			m = MODE_ACK;
			a = seq_t'(sb.nxt);
		end else if (r < 93) begin
			m = MODE_ACK;
			a = seq_t'(sb.base - 1);
		end else begin
			m = mode_t'($urandom_range(3));
		end
		push_cmd(m, a);
	endtask

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = REG_WIN_LEN;
		wr_data        = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.mode    = MODE_SEND;
		cmd_ch.ack_seq = '0;
		res_ch.ready   = 1'b0;
		idle_cycles    = 0;
		tx_idle_pct    = 34;
		rx_idle_pct    = 53;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: window 4, total 16
		push_cmd(MODE_UNUSED, 16'hFFFF);
		push_cmd(MODE_TICK, '0);
		push_cmd(MODE_ACK, 16'd0);
		push_cmd(MODE_SEND, '0);
		push_cmd(MODE_SEND, 16'hFFFF);
		push_cmd(MODE_TICK, '0);
		push_cmd(MODE_ACK, 16'd2);
		push_cmd(MODE_TICK, '0);
		push_cmd(MODE_ACK, 16'd0);
		push_cmd(MODE_ACK, 16'd1);
		push_cmd(MODE_ACK, 16'd0);
		push_cmd(MODE_ACK, 16'd4);
		push_cmd(MODE_ACK, 16'd3);
		push_cmd(MODE_SEND, '0);

		// zero window, upper data bits set to check the field width
		reconfig(16'hFFE0, 16'd16);
		push_cmd(MODE_SEND, '0);
		push_cmd(MODE_TICK, '0);

		// window above the slot count, largest total: a full burst of new beats
		reconfig(16'hFFFF, 16'hFFFF);
		for (int s = 4; s < 8; s++) begin
			push_cmd(MODE_ACK, seq_t'(s));
		end
		push_cmd(MODE_SEND, '0);
		push_cmd(MODE_TICK, '0);

		// total dropped under next: outstanding numbers remain live
		reconfig(16'hFFFF, 16'd0);
		push_cmd(MODE_SEND, '0);
		push_cmd(MODE_ACK, 16'd23);
		push_cmd(MODE_TICK, '0);

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				drain();
				tx_idle_pct = 53;
				rx_idle_pct = 34;
			end else if (p == 4) begin
				drain();
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (p)
				0: reconfig(seq_t'(16), seq_t'(sb.base + 48));
				1: reconfig(seq_t'(1), seq_t'(sb.base + 20));
				2: reconfig(seq_t'($urandom_range(15, 2)), seq_t'(sb.base + $urandom_range(60, 10)));
				3: reconfig(16'hFFFF, 16'hFFFF);
				4: reconfig(seq_t'($urandom_range(16, 1)), seq_t'(sb.base + $urandom_range(40, 1)));
				default: reconfig(seq_t'(16), seq_t'(sb.base + 64));
			endcase
			repeat (PHASE_ITEMS) random_item();
		end

		drain();
		if (sb.errors == 0) begin
			$display("sliding_window_sender_top test passed");
		end else begin
			$display("sliding_window_sender_top test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/swin_pkg.sv
hw/rtl/swin_cmd_if.sv
hw/rtl/swin_res_if.sv
hw/rtl/sliding_window_sender_top.sv
sim/sliding_window_sender_top_tb.sv
